// ===== hdl/ilp_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer literal parser package
// Shared types, status codes, queue sizing and per-type range limits.
// ----------------------------------------------------------------------------
package ilp_pkg;

	localparam int VALUE_BITS = 64;

	// Depth of the two short queues (front to back, back to result port)
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Largest magnitude the accumulator keeps: 2^(VALUE_BITS-1)
	localparam logic [VALUE_BITS-1:0] MAG_LIM = {1'b1, {(VALUE_BITS-1){1'b0}}};

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNEXP_END = 2'd1;
	localparam logic [1:0] ST_INVALID   = 2'd2;
	localparam logic [1:0] ST_EXP_DELIM = 2'd3;

	localparam logic [2:0] T_I8  = 3'd0;
	localparam logic [2:0] T_U8  = 3'd1;
	localparam logic [2:0] T_I16 = 3'd2;
	localparam logic [2:0] T_U16 = 3'd3;
	localparam logic [2:0] T_I32 = 3'd4;
	localparam logic [2:0] T_U32 = 3'd5;
	localparam logic [2:0] T_I64 = 3'd6;
	localparam logic [2:0] T_U64 = 3'd7;

	typedef struct packed {
		logic [7:0] char_code;
		logic       start_req;
		logic       end_of_line;
		logic [2:0] num_type;
		logic [7:0] delimiter;
	} ilp_in_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [1:0]         status;
		logic [15:0]        consumed;
	} ilp_out_t;

	// Classified character handed from the front to the back
	typedef struct packed {
		logic       start;
		logic       eol;
		logic       ws;
		logic       plus;
		logic       minus;
		logic       is_x;
		logic       nul;
		logic       eq_delim;
		logic       delim_none;
		logic       digit_ok;
		logic [3:0] digit;
		logic [2:0] num_type;
	} ilp_class_t;

	function automatic logic [63:0] type_max(input logic [2:0] t);
		logic [63:0] r;
		case (t)
			T_I8:    r = 64'd127;
			T_U8:    r = 64'd255;
			T_I16:   r = 64'd32767;
			T_U16:   r = 64'd65535;
			T_I32:   r = 64'd2147483647;
			T_U32:   r = 64'd4294967295;
			T_I64:   r = 64'h7FFF_FFFF_FFFF_FFFF;
			T_U64:   r = 64'h7FFF_FFFF_FFFF_FFFF;
			default: r = 64'd0;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] type_neg(input logic [2:0] t);
		logic [63:0] r;
		case (t)
			T_I8:    r = 64'd128;
			T_I16:   r = 64'd32768;
			T_I32:   r = 64'd2147483648;
			T_I64:   r = 64'h8000_0000_0000_0000;
			default: r = 64'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/integer_literal_parser.sv =====
// The parser takes one character per cycle and sustains that rate as long as
// results are popped; a request accepted into the front queue is parsed when
// the back end takes it from the queue head, and its result, if it ends the
// literal, is written into the result queue at that same edge and reaches
// the result port after older results are popped. The rate is set by the
// back end's single step per character, which holds one 64-bit multiply-by-
// radix add and compare for the digit accumulation. Two-entry queues sit
// between the front end and the back end and in front of the result port,
// so either side may stall. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
// Integer literal parser top level
// Auto-base integer literal parser with range check and delimiter handling.
// ----------------------------------------------------------------------------
module integer_literal_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  ilp_pkg::ilp_in_t  item,
	output logic              empty,
	input  logic              pop,
	output ilp_pkg::ilp_out_t result
);
	import ilp_pkg::*;

	logic       head_valid;
	ilp_class_t head;
	logic       head_take;
	logic       res_space;
	logic       res_push;
	ilp_out_t   res_data;

	ilp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.head_valid (head_valid),
		.head       (head),
		.head_take  (head_take)
	);

	ilp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_take  (head_take),
		.res_space  (res_space),
		.res_push   (res_push),
		.res_data   (res_data)
	);

	ilp_res_q u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_push),
		.wr_data (res_data),
		.space   (res_space),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ===== hdl/ilp_front.sv =====
// ----------------------------------------------------------------------------
// Integer literal parser front end
// Accepts characters, classifies them and queues the classified requests.
// ----------------------------------------------------------------------------
module ilp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  ilp_pkg::ilp_in_t    item,
	output logic                head_valid,
	output ilp_pkg::ilp_class_t head,
	input  logic                head_take
);
	import ilp_pkg::*;

	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_0     = 8'd48;
	localparam logic [7:0] CH_9     = 8'd57;
	localparam logic [7:0] CH_UA    = 8'd65;
	localparam logic [7:0] CH_UF    = 8'd70;
	localparam logic [7:0] CH_UX    = 8'd88;
	localparam logic [7:0] CH_LA    = 8'd97;
	localparam logic [7:0] CH_LF    = 8'd102;
	localparam logic [7:0] CH_LX    = 8'd120;

	logic [7:0]        dlm_q;
	ilp_class_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	ilp_class_t cls;
	logic [7:0] eff_dlm;
	logic       live;
	logic       wr_en;
	logic       rd_en;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = head_take && head_valid;

	always_comb begin
		eff_dlm = item.start_req ? item.delimiter : dlm_q;
		live    = !item.end_of_line;
		cls            = '0;
		cls.start      = item.start_req;
		cls.eol        = item.end_of_line;
		cls.num_type   = item.num_type;
		cls.delim_none = (eff_dlm == 8'd0);
		cls.ws    = live && (item.char_code == CH_SPACE ||
			(item.char_code >= CH_TAB && item.char_code <= CH_CR));
		cls.plus  = live && (item.char_code == CH_PLUS);
		cls.minus = live && (item.char_code == CH_MINUS);
		cls.is_x  = live && (item.char_code == CH_LX || item.char_code == CH_UX);
		cls.nul   = live && (item.char_code == 8'd0);
		cls.eq_delim = live && (item.char_code == eff_dlm);
		if (item.char_code >= CH_0 && item.char_code <= CH_9) begin
			cls.digit    = 4'(item.char_code - CH_0);
			cls.digit_ok = live;
		end else if (item.char_code >= CH_LA && item.char_code <= CH_LF) begin
			cls.digit    = 4'(item.char_code - CH_LA + 8'd10);
			cls.digit_ok = live;
		end else if (item.char_code >= CH_UA && item.char_code <= CH_UF) begin
			cls.digit    = 4'(item.char_code - CH_UA + 8'd10);
			cls.digit_ok = live;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlm_q <= '0;
		end else if (wr_en && item.start_req) begin
			dlm_q <= item.delimiter;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/ilp_back.sv =====
// ----------------------------------------------------------------------------
// Integer literal parser back end
// Parse FSM taking one classified character per cycle while results have room.
// ----------------------------------------------------------------------------
module ilp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  ilp_pkg::ilp_class_t head,
	output logic                head_take,
	input  logic                res_space,
	output logic                res_push,
	output ilp_pkg::ilp_out_t   res_data
);
	import ilp_pkg::*;

	localparam logic [2:0] P_IDLE   = 3'd0;
	localparam logic [2:0] P_LEAD   = 3'd1;
	localparam logic [2:0] P_SIGN   = 3'd2;
	localparam logic [2:0] P_ZERO   = 3'd3;
	localparam logic [2:0] P_XPEND  = 3'd4;
	localparam logic [2:0] P_DIGITS = 3'd5;
	localparam logic [2:0] P_TRAIL  = 3'd6;

	localparam logic [1:0] R_DEC = 2'd0;
	localparam logic [1:0] R_OCT = 2'd1;
	localparam logic [1:0] R_HEX = 2'd2;

	typedef struct packed {
		logic        emit;
		logic        trail;
		logic [1:0]  status;
		logic [63:0] value;
		logic [15:0] count;
	} fol_t;

	function automatic logic [15:0] inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// Outcome of the character that follows a finished, in-range literal
	function automatic fol_t follow(input logic eol, input logic ws, input logic nul,
		input logic eq, input logic dnone, input logic [63:0] v, input logic [15:0] cnt);
		fol_t r;
		r = '0;
		r.emit  = 1'b1;
		r.value = v;
		r.count = cnt;
		if (eol) begin
			r.status = ST_OK;
		end else if (dnone) begin
			r.status = ws ? ST_OK : ST_INVALID;
			if (!ws) begin
				r.value = '0;
			end
		end else if (ws) begin
			r.emit  = 1'b0;
			r.trail = 1'b1;
			r.count = inc16(cnt);
		end else begin
			r.count = inc16(cnt);
			if (nul || eq) begin
				r.status = ST_OK;
			end else begin
				r.status = ST_EXP_DELIM;
				r.value  = '0;
			end
		end
		return r;
	endfunction

	logic [2:0]            phase_q;
	logic                  neg_q;
	logic [1:0]            radix_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  ovf_q;
	logic [2:0]            type_q;
	logic                  dnone_q;
	logic [15:0]           cnt_q;
	logic [15:0]           lead_q;
	logic                  xdelim_q;
	logic [63:0]           fin_q;

	// effective state after a start request
	logic [2:0]            ph;
	logic                  ng;
	logic [1:0]            rx;
	logic [VALUE_BITS-1:0] mg;
	logic                  ov;
	logic [2:0]            ty;
	logic                  dn;
	logic [15:0]           ct;
	logic [15:0]           ld;

	logic [2:0]            ph_n;
	logic                  ng_n;
	logic [1:0]            rx_n;
	logic [VALUE_BITS-1:0] mg_n;
	logic                  ov_n;
	logic [15:0]           ct_n;
	logic [15:0]           ld_n;
	logic                  xd_n;
	logic [63:0]           fin_n;

	logic                  fin_ok;
	logic [63:0]           fin_val;
	logic [VALUE_BITS-1:0] sat;
	logic [VALUE_BITS+4:0] prod;
	logic [VALUE_BITS+4:0] acc;
	logic [4:0]            base;
	logic                  do_first;
	logic                  do_finish;
	logic                  do_finish_x;
	logic                  emit;
	fol_t                  fol;
	logic [15:0]           cdec;
	logic [1:0]            r_status;
	logic [63:0]           r_value;
	logic [15:0]           r_count;

	assign head_take = head_valid && res_space;
	assign res_push  = head_take && emit;

	always_comb begin
		res_data          = '0;
		res_data.value    = r_value;
		res_data.status   = r_status;
		res_data.consumed = r_count;
	end

	// Range check of the accumulated magnitude against the held type
	always_comb begin
		if (ng && mg != '0) begin
			sat     = (ov || mg > MAG_LIM) ? MAG_LIM : mg;
			fin_ok  = 64'(sat) <= type_neg(ty);
			fin_val = 64'd0 - 64'(sat);
		end else begin
			sat     = (ov || mg > MAG_LIM - 1'b1) ? MAG_LIM - 1'b1 : mg;
			fin_ok  = 64'(sat) <= type_max(ty);
			fin_val = 64'(sat);
		end
	end

	// Multiply by the radix with shifts, add the digit
	always_comb begin
		case (rx)
			R_OCT:   base = 5'd8;
			R_HEX:   base = 5'd16;
			default: base = 5'd10;
		endcase
		case (rx)
			R_OCT:   prod = {5'b0, mg} << 3;
			R_HEX:   prod = {5'b0, mg} << 4;
			default: prod = ({5'b0, mg} << 3) + ({5'b0, mg} << 1);
		endcase
		acc = prod + (VALUE_BITS + 5)'(head.digit);
	end

	always_comb begin
		ph = phase_q;
		ng = neg_q;
		rx = radix_q;
		mg = mag_q;
		ov = ovf_q;
		ty = type_q;
		dn = dnone_q;
		ct = cnt_q;
		ld = lead_q;
		if (head.start) begin
			ph = P_LEAD;
			ng = 1'b0;
			rx = R_DEC;
			mg = '0;
			ov = 1'b0;
			ty = head.num_type;
			dn = head.delim_none;
			ct = '0;
			ld = '0;
		end

		ph_n  = ph;
		ng_n  = ng;
		rx_n  = rx;
		mg_n  = mg;
		ov_n  = ov;
		ct_n  = ct;
		ld_n  = ld;
		xd_n  = head.start ? 1'b0 : xdelim_q;
		fin_n = fin_q;
		do_first    = 1'b0;
		do_finish   = 1'b0;
		do_finish_x = 1'b0;
		emit     = 1'b0;
		r_status = ST_OK;
		r_value  = '0;
		r_count  = ct;
		cdec     = (ct == 16'hFFFF) ? ct : ct - 16'd1;
		fol      = '0;

		unique case (ph)
			P_IDLE: begin
			end
			P_LEAD: begin
				if (head.eol) begin
					emit     = 1'b1;
					r_status = ST_UNEXP_END;
				end else if (head.ws) begin
					ct_n = inc16(ct);
				end else begin
					ld_n = ct;
					if (head.plus || head.minus) begin
						ng_n = head.minus;
						ct_n = inc16(ct);
						ph_n = P_SIGN;
					end else begin
						do_first = 1'b1;
					end
				end
			end
			P_SIGN: begin
				do_first = 1'b1;
			end
			P_ZERO: begin
				if (head.is_x) begin
					xd_n = head.eq_delim;
					ct_n = inc16(ct);
					ph_n = P_XPEND;
				end else if (head.digit_ok && head.digit < 4'd8) begin
					mg_n = VALUE_BITS'(head.digit);
					ct_n = inc16(ct);
					ph_n = P_DIGITS;
				end else begin
					do_finish = 1'b1;
				end
			end
			P_XPEND: begin
				if (head.digit_ok) begin
					rx_n = R_HEX;
					mg_n = VALUE_BITS'(head.digit);
					ct_n = inc16(ct);
					ph_n = P_DIGITS;
				end else begin
					do_finish_x = 1'b1;
				end
			end
			P_DIGITS: begin
				if (head.digit_ok && 5'(head.digit) < base) begin
					ct_n = inc16(ct);
					if (!ov) begin
						if (acc > (VALUE_BITS + 5)'(MAG_LIM)) begin
							ov_n = 1'b1;
							mg_n = MAG_LIM;
						end else begin
							mg_n = acc[VALUE_BITS-1:0];
						end
					end
				end else begin
					do_finish = 1'b1;
				end
			end
			P_TRAIL: begin
				fol = follow(head.eol, head.ws, head.nul, head.eq_delim, dn, fin_q, ct);
			end
			default: begin
			end
		endcase

		if (do_first) begin
			if (!(head.digit_ok && head.digit <= 4'd9)) begin
				emit     = 1'b1;
				r_status = ST_INVALID;
				r_count  = ld_n;
			end else begin
				ct_n = inc16(ct);
				mg_n = VALUE_BITS'(head.digit);
				if (head.digit == 4'd0) begin
					rx_n = R_OCT;
					ph_n = P_ZERO;
				end else begin
					rx_n = R_DEC;
					ph_n = P_DIGITS;
				end
			end
		end

		if (do_finish) begin
			if (!fin_ok) begin
				emit     = 1'b1;
				r_status = ST_INVALID;
				r_count  = ld;
			end else begin
				fol = follow(head.eol, head.ws, head.nul, head.eq_delim, dn, fin_val, ct);
			end
		end

		// literal is a bare zero; the held x is its follower
		if (do_finish_x) begin
			fol = follow(1'b0, 1'b0, 1'b0, xdelim_q && !head.start, dn, 64'd0, cdec);
		end

		if (fol.emit) begin
			emit     = 1'b1;
			r_status = fol.status;
			r_value  = fol.value;
			r_count  = fol.count;
		end
		if (fol.trail) begin
			ct_n  = fol.count;
			fin_n = fol.value;
			ph_n  = P_TRAIL;
		end
		if (emit) begin
			ph_n = P_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= P_IDLE;
			neg_q    <= 1'b0;
			radix_q  <= R_DEC;
			mag_q    <= '0;
			ovf_q    <= 1'b0;
			type_q   <= '0;
			dnone_q  <= 1'b1;
			cnt_q    <= '0;
			lead_q   <= '0;
			xdelim_q <= 1'b0;
			fin_q    <= '0;
		end else if (head_take) begin
			phase_q  <= ph_n;
			neg_q    <= ng_n;
			radix_q  <= rx_n;
			mag_q    <= mg_n;
			ovf_q    <= ov_n;
			type_q   <= ty;
			dnone_q  <= dn;
			cnt_q    <= ct_n;
			lead_q   <= ld_n;
			xdelim_q <= xd_n;
			fin_q    <= fin_n;
		end
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> res_space)
		else $error("result pushed into a full queue");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		head_take && !head.start && phase_q == P_IDLE |-> !res_push)
		else $error("result produced outside a parse");

	a_result_ends_parse: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> phase_q == P_IDLE)
		else $error("parse kept running after its result");

	a_error_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_data.status != ST_OK |-> res_data.value == 64'sd0)
		else $error("error result carries a nonzero value");

endmodule

// ===== hdl/ilp_res_q.sv =====
// ----------------------------------------------------------------------------
// Integer literal parser result queue
// Holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module ilp_res_q (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  ilp_pkg::ilp_out_t wr_data,
	output logic              space,
	output logic              empty,
	input  logic              pop,
	output ilp_pkg::ilp_out_t result
);
	import ilp_pkg::*;

	ilp_out_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              wr_en;
	logic              rd_en;

	assign space  = (count_q != QCNT_W'(QDEPTH));
	assign empty  = (count_q == '0);
	assign result = mem_q[rd_ptr_q];
	assign wr_en  = wr && space;
	assign rd_en  = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer literal parser testbench
// Streams lines into the parser one character per request. Each
// accepted request goes through a cycle-free model of the parse, and every
// popped result is checked field by field against the oldest predicted one.
// Both sides idle at random, and the sender holds twice until the parser
// has drained.
// ----------------------------------------------------------------------------
module tb_top;
	import ilp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int STREAM_TARGET  = 450;
	localparam logic [63:0] MAG_CAP = 64'h8000_0000_0000_0000;

	// Largest positive and negative magnitude of each target type, by type code
	localparam logic [63:0] POS_REACH [8] = '{
		64'd127, 64'd255, 64'd32767, 64'd65535, 64'd2147483647, 64'd4294967295,
		64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF};
	localparam logic [63:0] NEG_REACH [8] = '{
		64'd128, 64'd0, 64'd32768, 64'd0, 64'd2147483648, 64'd0,
		64'h8000_0000_0000_0000, 64'd0};

	typedef enum logic [2:0] {
		PH_IDLE, PH_LEAD, PH_SIGN, PH_ZERO, PH_XPEND, PH_DIGITS, PH_TRAIL
	} parse_phase_e;

	typedef enum logic [1:0] {RX_DEC, RX_OCT, RX_HEX} radix_e;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     push   = 1'b0;
	logic     pop    = 1'b0;
	ilp_in_t  item   = '0;
	logic     full;
	logic     empty;
	ilp_out_t result;

	integer_literal_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Parse model state
	parse_phase_e ph = PH_IDLE;
	radix_e       rx = RX_DEC;
	logic         neg_f = 1'b0;
	logic         ovf = 1'b0;
	logic [63:0]  mag = '0;
	logic [2:0]   ty = '0;
	logic [7:0]   dlm = '0;
	logic [15:0]  cnt = '0;
	logic [15:0]  lead_n = '0;
	logic [7:0]   held_x = '0;

	ilp_in_t  char_stream[$];
	ilp_out_t parse_results_due[$];
	int       drain_marks[$];
	logic [7:0] line_buf[$];

	int chars_sent = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b1;
	bit req_taken = 1'b0;
	bit res_taken = 1'b0;

	function automatic logic [15:0] sat_inc(logic [15:0] n);
		return (n == 16'hFFFF) ? n : n + 16'd1;
	endfunction

	function automatic bit is_space(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic int digit_val(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return 99;
	endfunction

	function automatic ilp_out_t emit_res(logic [63:0] v, logic [1:0] st, logic [15:0] n);
		ilp_out_t r;
		r.value = v;
		r.status = st;
		r.consumed = n;
		ph = PH_IDLE;
		return r;
	endfunction

	function automatic void add_digit(int d, int base);
		logic [63:0] dv;
		logic [63:0] bv;
		dv = 64'(d);
		bv = 64'(base);
		if (ovf) return;
		if (mag > (MAG_CAP - dv) / bv) begin
			ovf = 1'b1;
			mag = MAG_CAP;
		end else begin
			mag = mag * bv + dv;
		end
	endfunction

	// Saturate, check against the target type, leave two's complement in mag
	function automatic bit fit_range();
		logic [63:0] m;
		m = mag;
		if (neg_f && m != 64'd0) begin
			if (ovf || m > MAG_CAP) m = MAG_CAP;
			if (m > NEG_REACH[ty]) return 1'b0;
			mag = -m;
		end else begin
			if (ovf || m > MAG_CAP - 64'd1) m = MAG_CAP - 64'd1;
			if (m > POS_REACH[ty]) return 1'b0;
			mag = m;
		end
		return 1'b1;
	endfunction

	function automatic bit follow_char(logic [7:0] c, bit eol, output ilp_out_t r);
		if (eol) begin
			r = emit_res(mag, ST_OK, cnt);
			return 1'b1;
		end
		if (dlm == 8'd0) begin
			if (is_space(c)) r = emit_res(mag, ST_OK, cnt);
			else r = emit_res('0, ST_INVALID, cnt);
			return 1'b1;
		end
		if (is_space(c)) begin
			cnt = sat_inc(cnt);
			ph = PH_TRAIL;
			return 1'b0;
		end
		// a zero code ends the line here but still counts
		if (c == 8'd0 || c == dlm) r = emit_res(mag, ST_OK, sat_inc(cnt));
		else r = emit_res('0, ST_EXP_DELIM, sat_inc(cnt));
		return 1'b1;
	endfunction

	function automatic bit close_literal(logic [7:0] c, bit eol, output ilp_out_t r);
		if (!fit_range()) begin
			r = emit_res('0, ST_INVALID, lead_n);
			return 1'b1;
		end
		return follow_char(c, eol, r);
	endfunction

	function automatic bit next_parse_result(ilp_in_t it, output ilp_out_t r);
		logic [7:0] c;
		bit eol;
		int d;
		int base;
		c = it.char_code;
		eol = it.end_of_line;
		if (it.start_req) begin
			neg_f = 1'b0;
			rx = RX_DEC;
			mag = '0;
			ovf = 1'b0;
			ty = it.num_type;
			dlm = it.delimiter;
			cnt = '0;
			lead_n = '0;
			held_x = '0;
			ph = PH_LEAD;
		end
		d = eol ? 99 : digit_val(c);
		base = (rx == RX_HEX) ? 16 : ((rx == RX_OCT) ? 8 : 10);
		if (ph == PH_LEAD) begin
			if (eol) begin
				r = emit_res('0, ST_UNEXP_END, cnt);
				return 1'b1;
			end
			if (is_space(c)) begin
				cnt = sat_inc(cnt);
				return 1'b0;
			end
			lead_n = cnt;
			if (c == "+" || c == "-") begin
				neg_f = (c == "-");
				cnt = sat_inc(cnt);
				ph = PH_SIGN;
				return 1'b0;
			end
			// no sign: this character is the first digit
			ph = PH_SIGN;
		end
		case (ph)
			PH_SIGN: begin
				if (d > 9) begin
					r = emit_res('0, ST_INVALID, lead_n);
					return 1'b1;
				end
				cnt = sat_inc(cnt);
				if (d == 0) begin
					rx = RX_OCT;
					mag = '0;
					ph = PH_ZERO;
				end else begin
					rx = RX_DEC;
					mag = 64'(d);
					ph = PH_DIGITS;
				end
				return 1'b0;
			end
			PH_ZERO: begin
				if (!eol && (c == "x" || c == "X")) begin
					held_x = c;
					cnt = sat_inc(cnt);
					ph = PH_XPEND;
					return 1'b0;
				end
				if (d < 8) begin
					mag = 64'(d);
					cnt = sat_inc(cnt);
					ph = PH_DIGITS;
					return 1'b0;
				end
				return close_literal(c, eol, r);
			end
			PH_XPEND: begin
				if (d < 16) begin
					rx = RX_HEX;
					mag = 64'(d);
					cnt = sat_inc(cnt);
					ph = PH_DIGITS;
					return 1'b0;
				end
				// literal was a bare zero; the held x becomes its follower
				if (cnt != 16'hFFFF) cnt = cnt - 16'd1;
				mag = '0;
				neg_f = 1'b0;
				return close_literal(held_x, 1'b0, r);
			end
			PH_DIGITS: begin
				if (d < base) begin
					add_digit(d, base);
					cnt = sat_inc(cnt);
					return 1'b0;
				end
				return close_literal(c, eol, r);
			end
			PH_TRAIL: return follow_char(c, eol, r);
			default: return 1'b0;
		endcase
	endfunction

	// Stimulus building
	function automatic void put(logic [7:0] c, bit st, bit eol, logic [2:0] t, logic [7:0] dl);
		ilp_in_t it;
		it.char_code = eol ? 8'($urandom) : c;
		it.start_req = st;
		it.end_of_line = eol;
		it.num_type = st ? t : 3'($urandom);
		it.delimiter = st ? dl : 8'($urandom);
		char_stream = {char_stream, it};
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) line_buf = {line_buf, s[i]};
	endfunction

	function automatic void flush_line(logic [2:0] t, logic [7:0] dl, bit eol_after);
		if (line_buf.size() == 0) begin
			put(8'd0, 1'b1, 1'b1, t, dl);
		end else begin
			foreach (line_buf[i]) put(line_buf[i], i == 0, 1'b0, t, dl);
			if (eol_after) put(8'd0, 1'b0, 1'b1, t, dl);
		end
		line_buf.delete();
	endfunction

	function automatic void add_line(string s, logic [2:0] t, logic [7:0] dl);
		add_text(s);
		flush_line(t, dl, 1'b1);
	endfunction

	function automatic string space_run(int n);
		string s;
		int k;
		s = "";
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 5);
			s = {s, $sformatf("%c", (k == 5) ? 32 : 9 + k)};
		end
		return s;
	endfunction

	function automatic logic [63:0] pick_mag(logic [2:0] t, bit neg);
		case ($urandom_range(0, 3))
			0: return (neg ? NEG_REACH[t] : POS_REACH[t]) + 64'($urandom_range(0, 2)) - 64'd1;
			1: return {$urandom, $urandom};
			default: return {$urandom, $urandom} >> $urandom_range(40, 63);
		endcase
	endfunction

	function automatic void random_literal();
		string dl_set;
		string digits;
		logic [2:0] t;
		logic [7:0] dl;
		logic [63:0] v;
		int sg;
		int fk;
		int k;
		dl_set = ",;:=x]";
		t = 3'($urandom);
		k = $urandom_range(0, 6);
		if ($urandom_range(0, 1)) dl = 8'd0;
		else dl = (k == 6) ? 8'($urandom_range(1, 255)) : dl_set[k];
		add_text(space_run($urandom_range(0, 2)));
		sg = $urandom_range(0, 2);
		if (sg == 1) add_text("+");
		if (sg == 2) add_text("-");
		v = pick_mag(t, sg == 2);
		case ($urandom_range(0, 7))
			0, 1, 2, 3: digits = $sformatf("%0d", v);
			4, 5:       digits = $sformatf("0%0o", v);
			6:          digits = $sformatf("0x%0h", v);
			default:    digits = "0x";
		endcase
		if ($urandom_range(0, 1)) digits = digits.toupper();
		// push past the 64-bit range now and then
		if ($urandom_range(0, 9) == 0) digits = {digits, "7777"};
		add_text(digits);
		fk = $urandom_range(0, 7);
		case (fk)
			1: add_text({space_run(1), "z"});
			2: if (dl != 8'd0) line_buf = {line_buf, dl};
			3: begin
				add_text(space_run($urandom_range(1, 2)));
				if (dl != 8'd0) line_buf = {line_buf, dl};
			end
			4: line_buf = {line_buf, 8'($urandom)};
			5: line_buf = {line_buf, 8'd0};
			default: ;
		endcase
		// leave the line open sometimes so the next start cuts it off
		flush_line(t, dl, fk != 6);
	endfunction

	function automatic int next_gap(inout bit calm);
		if ($urandom_range(0, 31) == 0) calm = !calm;
		return calm ? 0 : $urandom_range(0, 15);
	endfunction

	// Request side
	always @(negedge clk) begin
		if (req_taken) begin
			req_taken = 1'b0;
			void'(char_stream.pop_front());
			send_gap = next_gap(send_calm);
		end
		if (drain_marks.size() != 0 && chars_sent >= drain_marks[0] &&
				parse_results_due.size() == 0)
			void'(drain_marks.pop_front());
		if (!arst_n || send_gap != 0 || char_stream.size() == 0 ||
				(drain_marks.size() != 0 && chars_sent >= drain_marks[0])) begin
			push <= 1'b0;
			if (arst_n && send_gap != 0) send_gap--;
		end else begin
			push <= 1'b1;
			item <= char_stream[0];
		end
	end

	// Result side
	always @(negedge clk) begin
		if (res_taken) begin
			res_taken = 1'b0;
			recv_gap = next_gap(recv_calm);
		end
		if (recv_gap != 0) begin
			pop <= 1'b0;
			recv_gap--;
		end else begin
			pop <= arst_n;
		end
	end

	always @(posedge clk) begin
		ilp_out_t due;
		bit moved;
		moved = 1'b0;
		if (arst_n && push && !full) begin
			if (next_parse_result(item, due)) parse_results_due = {parse_results_due, due};
			chars_sent++;
			req_taken = 1'b1;
			moved = 1'b1;
		end
		if (arst_n && pop && !empty) begin
			moved = 1'b1;
			res_taken = 1'b1;
			if (parse_results_due.size() == 0) begin
				$error("unexpected result: value %0d status %0d consumed %0d",
					result.value, result.status, result.consumed);
				mismatches++;
			end else begin
				due = parse_results_due.pop_front();
				if (result.value !== due.value) begin
					$error("value: expected %0d, got %0d", due.value, result.value);
					mismatches++;
				end
				if (result.status !== due.status) begin
					$error("status: expected %0d, got %0d", due.status, result.status);
					mismatches++;
				end
				if (result.consumed !== due.consumed) begin
					$error("consumed: expected %0d, got %0d", due.consumed, result.consumed);
					mismatches++;
				end
			end
		end
		if (!arst_n || moved) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL integer_literal_parser");
			$finish;
		end
	end

	initial begin
		bit mid_marked;
		mid_marked = 1'b0;

		add_line("", T_I8, 8'd0);
		add_line(" \t ", T_I32, 8'd0);
		add_line("127", T_I8, 8'd0);
		add_line("-128", T_I8, 8'd0);
		add_line("128", T_I8, 8'd0);
		add_line("-1", T_U8, 8'd0);
		add_line("255 ", T_U8, 8'd0);
		add_line("-2147483648", T_I32, 8'd0);
		add_line("4294967295", T_U32, 8'd0);
		add_line("-9223372036854775808", T_I64, 8'd0);
		add_line("0x7FFFFFFFFFFFFFFF", T_U64, 8'd0);
		add_line("99999999999999999999", T_I64, 8'd0);
		add_line("0777", T_U16, 8'd0);
		add_line("08", T_I16, 8'd0);
		add_line("0x", T_I32, 8'd0);
		add_line("0xg", T_I32, "x");
		add_line("-0X1f", T_I8, 8'd0);
		add_line("+12 \t;", T_I8, ";");
		add_line("7,", T_I8, ";");
		add_text("5");
		line_buf = {line_buf, 8'd0};
		flush_line(T_I8, ",", 1'b1);
		add_line("12a", T_I16, 8'd0);
		add_line("abc", T_I8, 8'd0);
		add_line("-", T_I8, 8'd0);
		// restart mid-literal, then characters with no parse open
		add_text("123");
		flush_line(T_I8, 8'd0, 1'b0);
		add_line("4", T_I8, 8'd0);
		put("9", 1'b0, 1'b0, T_I8, 8'd0);
		put(8'd0, 1'b0, 1'b1, T_I8, 8'd0);
		drain_marks = {drain_marks, char_stream.size()};

		while (char_stream.size() < STREAM_TARGET) begin
			if ($urandom_range(0, 4) == 0) begin
				for (int i = $urandom_range(1, 6); i > 0; i--)
					line_buf = {line_buf, 8'($urandom)};
				flush_line(3'($urandom), $urandom_range(0, 1) ? 8'd0 : 8'($urandom),
					1'($urandom_range(0, 1)));
				for (int i = $urandom_range(0, 2); i > 0; i--)
					put(8'($urandom), 1'b0, $urandom_range(0, 3) == 0, 3'd0, 8'd0);
			end else begin
				random_literal();
			end
			if (!mid_marked && char_stream.size() >= STREAM_TARGET / 2) begin
				drain_marks = {drain_marks, char_stream.size()};
				mid_marked = 1'b1;
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (char_stream.size() != 0 || parse_results_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) $display("PASS integer_literal_parser");
		else $display("FAIL integer_literal_parser");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ilp_pkg.sv
hdl/ilp_front.sv
hdl/ilp_back.sv
hdl/ilp_res_q.sv
hdl/integer_literal_parser.sv
test/tb_top.sv
